// ===== rtl/bis_pkg.sv =====
package bis_pkg;

    // Field widths of the stream words and config registers
    localparam int COORD_W     = 13;
    localparam int CHAN_W      = 8;
    localparam int PIX_W       = 3 * CHAN_W;
    localparam int SIZE_W      = 10;
    localparam int DPI_W       = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 24;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;
    localparam int DEF_FRAC_BITS  = 8;

    // Reset values of the config registers
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(512);
    localparam logic [DPI_W-1:0]  DPI_RESET  = DPI_W'(72);

    // Command codes carried on s_tuser
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_INTERP = 1'b1;

    // Config register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_DPI = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_DPI   = 2'd3;

    // Four neighbor samples of one channel
    typedef struct packed {
        logic [CHAN_W-1:0] a;   // (x1, y1)
        logic [CHAN_W-1:0] b;   // (x2, y1)
        logic [CHAN_W-1:0] d;   // (x1, y2)
        logic [CHAN_W-1:0] e;   // (x2, y2)
    } quad_t;

    // Divider status
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // One result word handed to the output register
    typedef struct packed {
        logic              err;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } result_t;

endpackage

// ===== rtl/bilinear_image_scaler.sv =====
// Bilinear RGB888 scaler. A load word (s_tuser = 0) writes one source pixel
// into the on-chip frame store at (col, row), and while the block is idle a
// new word is taken every cycle; loads outside MAX_WIDTH x MAX_HEIGHT are
// dropped. An interpolate word (s_tuser = 1) names an output pixel of the
// image scaled by target_dpi/base_dpi and returns one RGB word; m_tuser = 1
// flags a position outside the output size floor(src*target/base), with zero
// color. For an interpolate word the two source coordinates go one after the
// other through one bit-serial divider, then the four neighbors come out of
// the single frame store read port, then three channel lanes blend them. An
// out-of-range position skips the divider, the reads and the lanes. A
// finished word sits in the output register, so the next input is taken
// while it waits. Config must be written only while the block is idle; the
// block itself does not enforce this. Pixels must be loaded before they are
// read as neighbors; the store is not cleared at reset.
module bilinear_image_scaler #(
    parameter int MAX_WIDTH  = bis_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bis_pkg::DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = bis_pkg::DEF_FRAC_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // col[12:0], row[25:13], in_red[33:26], in_green[41:34], in_blue[49:42]
    input  logic [bis_pkg::S_TDATA_W-1:0]   s_tdata,
    // command[0]
    input  logic [0:0]                      s_tuser,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_red[7:0], out_green[15:8], out_blue[23:16]
    output logic [bis_pkg::M_TDATA_W-1:0]   m_tdata,
    // status[0]
    output logic [0:0]                      m_tuser,
    // config write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bis_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bis_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int XW     = $clog2(MAX_WIDTH);
    localparam int YW     = $clog2(MAX_HEIGHT);
    localparam int MAXDIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int QW     = $clog2(MAXDIM) + FRAC_BITS;   // quotient width
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = bis_pkg::COORD_W;
    localparam int DPW    = bis_pkg::DPI_W;
    localparam int PW     = CW + 1 + DPW;                 // (pos+1)*base
    localparam int NW     = CW + DPW + FRAC_BITS;         // dividend width
    localparam int CH     = bis_pkg::CHAN_W;

    // s_tdata field positions
    localparam int COL_LSB   = 0;
    localparam int ROW_LSB   = COL_LSB + CW;
    localparam int RED_LSB   = ROW_LSB + CW;
    localparam int GREEN_LSB = RED_LSB + CH;
    localparam int BLUE_LSB  = GREEN_LSB + CH;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_CHECK, S_DIVX, S_DIVY, S_COORD,
        S_RD1, S_RD2, S_RD3, S_RD4, S_RDLAST, S_BLEND, S_EMIT
    } state_t;

    state_t state_reg;
    logic   err_reg;

    // ---------------- config registers ----------------
    logic [bis_pkg::SIZE_W-1:0] src_width_reg, src_height_reg;
    logic [DPW-1:0]             target_dpi_reg, base_dpi_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= bis_pkg::SIZE_RESET;
            src_height_reg <= bis_pkg::SIZE_RESET;
            target_dpi_reg <= bis_pkg::DPI_RESET;
            base_dpi_reg   <= bis_pkg::DPI_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                bis_pkg::REG_SRC_WIDTH:  src_width_reg  <= cfg_data[bis_pkg::SIZE_W-1:0];
                bis_pkg::REG_SRC_HEIGHT: src_height_reg <= cfg_data[bis_pkg::SIZE_W-1:0];
                bis_pkg::REG_TARGET_DPI: target_dpi_reg <= cfg_data;
                bis_pkg::REG_BASE_DPI:   base_dpi_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective sizes: zero reads as one, oversize saturates at the store size
    logic [XW:0]    w_eff, wm1;
    logic [YW:0]    h_eff, hm1;
    logic [DPW-1:0] bas_eff;

    always_comb begin
        if (src_width_reg == '0) begin
            w_eff = (XW+1)'(1);
        end else if (16'(src_width_reg) > 16'(MAX_WIDTH)) begin
            w_eff = (XW+1)'(MAX_WIDTH);
        end else begin
            w_eff = (XW+1)'(src_width_reg);
        end
        if (src_height_reg == '0) begin
            h_eff = (YW+1)'(1);
        end else if (16'(src_height_reg) > 16'(MAX_HEIGHT)) begin
            h_eff = (YW+1)'(MAX_HEIGHT);
        end else begin
            h_eff = (YW+1)'(src_height_reg);
        end
        wm1     = w_eff - (XW+1)'(1);
        hm1     = h_eff - (YW+1)'(1);
        bas_eff = (base_dpi_reg == '0) ? DPW'(1) : base_dpi_reg;
    end

    // ---------------- input unpack ----------------
    logic [CW-1:0] in_col, in_row;
    logic [CH-1:0] in_red, in_green, in_blue;
    logic          in_accept;

    assign in_col    = s_tdata[COL_LSB +: CW];
    assign in_row    = s_tdata[ROW_LSB +: CW];
    assign in_red    = s_tdata[RED_LSB +: CH];
    assign in_green  = s_tdata[GREEN_LSB +: CH];
    assign in_blue   = s_tdata[BLUE_LSB +: CH];
    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;

    // ---------------- frame store ----------------
    logic                      mem_we;
    logic [AW-1:0]             wr_addr, rd_addr;
    logic [bis_pkg::PIX_W-1:0] rd_data;

    assign mem_we  = in_accept && (s_tuser[0] == bis_pkg::CMD_LOAD)
                     && (in_col < CW'(MAX_WIDTH)) && (in_row < CW'(MAX_HEIGHT));
    assign wr_addr = AW'(AW'(in_row[YW-1:0]) * AW'(MAX_WIDTH)) + AW'(in_col[XW-1:0]);

    bis_frame_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (wr_addr),
        .wr_data ({in_red, in_green, in_blue}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ---------------- position check and mapping ----------------
    logic [CW-1:0]          col_reg, row_reg;
    logic [PW-1:0]          prod_cx_reg, prod_wt_reg, prod_ry_reg, prod_ht_reg;
    logic [CW:0]            col_inc, row_inc;
    logic [PW-1:0]          cx0, cy0;
    logic                   out_of_range;
    logic                   div_start;
    logic [NW-1:0]          div_dividend;
    logic [QW-1:0]          div_q, lim_x, lim_y, sx_clamp, sy_clamp;
    bis_pkg::div_stat_t     div_stat;
    logic [XW+FRAC_BITS-1:0] sx_reg;
    logic [YW+FRAC_BITS-1:0] sy_reg;

    always_comb begin
        col_inc = {1'b0, col_reg} + (CW+1)'(1);
        row_inc = {1'b0, row_reg} + (CW+1)'(1);
        // col >= floor(w*t/b)  <=>  w*t < (col+1)*b
        out_of_range = (prod_wt_reg < prod_cx_reg) || (prod_ht_reg < prod_ry_reg);
        cx0 = prod_cx_reg - PW'(bas_eff);
        cy0 = prod_ry_reg - PW'(bas_eff);
        div_start = ((state_reg == S_CHECK) && !out_of_range)
                    || ((state_reg == S_DIVX) && div_stat.done);
        if (state_reg == S_CHECK) begin
            div_dividend = {cx0[CW+DPW-1:0], {FRAC_BITS{1'b0}}};
        end else begin
            div_dividend = {cy0[CW+DPW-1:0], {FRAC_BITS{1'b0}}};
        end
        lim_x    = QW'({wm1[XW-1:0], {FRAC_BITS{1'b0}}});
        lim_y    = QW'({hm1[YW-1:0], {FRAC_BITS{1'b0}}});
        sx_clamp = (div_q > lim_x) ? lim_x : div_q;
        sy_clamp = (div_q > lim_y) ? lim_y : div_q;
    end

    bis_divider #(
        .NW (NW),
        .DW (DPW),
        .QW (QW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (target_dpi_reg),
        .stat     (div_stat),
        .quotient (div_q)
    );

    // ---------------- neighbor coordinates ----------------
    logic [XW-1:0]        x1, x2, x1_reg, x2_reg;
    logic [YW-1:0]        y1, y2;
    logic [XW:0]          x1_inc;
    logic [YW:0]          y1_inc;
    logic [FRAC_BITS-1:0] fx_reg, fy_reg;
    logic [AW-1:0]        yb1_reg, yb2_reg;

    always_comb begin
        x1     = sx_reg[XW+FRAC_BITS-1:FRAC_BITS];
        y1     = sy_reg[YW+FRAC_BITS-1:FRAC_BITS];
        x1_inc = {1'b0, x1} + (XW+1)'(1);
        y1_inc = {1'b0, y1} + (YW+1)'(1);
        // second neighbor clamps at the right and bottom edges
        x2 = (x1_inc < w_eff) ? x1_inc[XW-1:0] : wm1[XW-1:0];
        y2 = (y1_inc < h_eff) ? y1_inc[YW-1:0] : hm1[YW-1:0];
        unique case (state_reg)
            S_RD2:   rd_addr = yb1_reg + AW'(x2_reg);
            S_RD3:   rd_addr = yb2_reg + AW'(x1_reg);
            S_RD4:   rd_addr = yb2_reg + AW'(x2_reg);
            default: rd_addr = yb1_reg + AW'(x1_reg);
        endcase
    end

    // ---------------- datapath registers ----------------
    logic [bis_pkg::PIX_W-1:0] p1_reg, p2_reg, p3_reg;

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            col_reg <= in_col;
            row_reg <= in_row;
        end
        if (state_reg == S_MUL) begin
            prod_cx_reg <= PW'(col_inc) * PW'(bas_eff);
            prod_ry_reg <= PW'(row_inc) * PW'(bas_eff);
            prod_wt_reg <= PW'(w_eff) * PW'(target_dpi_reg);
            prod_ht_reg <= PW'(h_eff) * PW'(target_dpi_reg);
        end
        if ((state_reg == S_DIVX) && div_stat.done) begin
            sx_reg <= sx_clamp[XW+FRAC_BITS-1:0];
        end
        if ((state_reg == S_DIVY) && div_stat.done) begin
            sy_reg <= sy_clamp[YW+FRAC_BITS-1:0];
        end
        if (state_reg == S_COORD) begin
            x1_reg  <= x1;
            x2_reg  <= x2;
            fx_reg  <= sx_reg[FRAC_BITS-1:0];
            fy_reg  <= sy_reg[FRAC_BITS-1:0];
            yb1_reg <= AW'(AW'(y1) * AW'(MAX_WIDTH));
            yb2_reg <= AW'(AW'(y2) * AW'(MAX_WIDTH));
        end
        // store read data is registered and follows its address in the next state
        if (state_reg == S_RD2) begin
            p1_reg <= rd_data;
        end
        if (state_reg == S_RD3) begin
            p2_reg <= rd_data;
        end
        if (state_reg == S_RD4) begin
            p3_reg <= rd_data;
        end
    end

    // ---------------- channel lanes ----------------
    logic          lane_start;
    logic [2:0]    lane_valid;
    logic [CH-1:0] lane_chan [3];

    assign lane_start = (state_reg == S_RDLAST);

    for (genvar c = 0; c < 3; c++) begin : g_lane
        localparam int SH = bis_pkg::PIX_W - CH * (c + 1);
        bis_pkg::quad_t quad;

        assign quad.a = p1_reg[SH +: CH];
        assign quad.b = p2_reg[SH +: CH];
        assign quad.d = p3_reg[SH +: CH];
        assign quad.e = rd_data[SH +: CH];

        bis_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (lane_start),
            .quad      (quad),
            .fx        (fx_reg),
            .fy        (fy_reg),
            .out_valid (lane_valid[c]),
            .chan      (lane_chan[c])
        );
    end

    // ---------------- output register ----------------
    logic             merge_free, merge_load;
    bis_pkg::result_t result;

    assign merge_load   = (state_reg == S_EMIT) && merge_free;
    assign result.err   = err_reg;
    assign result.red   = lane_chan[0];
    assign result.green = lane_chan[1];
    assign result.blue  = lane_chan[2];

    bis_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (merge_load),
        .result   (result),
        .free     (merge_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            err_reg   <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (in_accept && (s_tuser[0] == bis_pkg::CMD_INTERP)) begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: state_reg <= S_CHECK;
                S_CHECK: begin
                    err_reg   <= out_of_range;
                    state_reg <= out_of_range ? S_EMIT : S_DIVX;
                end
                S_DIVX: begin
                    if (div_stat.done) begin
                        state_reg <= S_DIVY;
                    end
                end
                S_DIVY: begin
                    if (div_stat.done) begin
                        state_reg <= S_COORD;
                    end
                end
                S_COORD:  state_reg <= S_RD1;
                S_RD1:    state_reg <= S_RD2;
                S_RD2:    state_reg <= S_RD3;
                S_RD3:    state_reg <= S_RD4;
                S_RD4:    state_reg <= S_RDLAST;
                S_RDLAST: state_reg <= S_BLEND;
                S_BLEND: begin
                    if (lane_valid[0]) begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (merge_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("error word carries nonzero color");

    a_interp_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && (s_tuser[0] == bis_pkg::CMD_INTERP)) |=> !s_tready)
        else $error("input taken while an interpolation is in flight");

    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_lanes_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        lane_valid[0] |-> (lane_valid[1] && lane_valid[2]))
        else $error("channel lanes out of step");
`endif

endmodule

// ===== rtl/bis_frame_store.sv =====
module bis_frame_store #(
    parameter int DEPTH = bis_pkg::DEF_MAX_WIDTH * bis_pkg::DEF_MAX_HEIGHT
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  logic [bis_pkg::PIX_W-1:0] wr_data,
    input  logic [$clog2(DEPTH)-1:0]  rd_addr,
    output logic [bis_pkg::PIX_W-1:0] rd_data
);

    logic [bis_pkg::PIX_W-1:0] store_mem [DEPTH];
    logic [bis_pkg::PIX_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/bis_divider.sv =====
// Restoring divider, one quotient bit per cycle. The caller guarantees
// that the quotient fits in QW bits.
module bis_divider #(
    parameter int NW = bis_pkg::COORD_W + bis_pkg::DPI_W + bis_pkg::DEF_FRAC_BITS,
    parameter int DW = bis_pkg::DPI_W,
    parameter int QW = 9 + bis_pkg::DEF_FRAC_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [NW-1:0]          dividend,
    input  logic [DW-1:0]          divisor,
    output bis_pkg::div_stat_t     stat,
    output logic [QW-1:0]          quotient
);

    localparam int CW = $clog2(QW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [QW-1:0] sh_reg, sh_next;
    logic [DW-1:0] div_reg, div_next;
    logic [DW:0]   trial;
    logic          ge;

    always_comb begin
        trial     = {rem_reg, sh_reg[QW-1]};
        ge        = (trial >= {1'b0, div_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        div_next  = div_reg;
        if (start && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next  = CW'(QW);
            rem_next  = dividend[NW-1:QW][DW-1:0];
            sh_next   = dividend[QW-1:0];
            div_next  = divisor;
        end else if (busy_reg) begin
            rem_next = ge ? DW'(trial - {1'b0, div_reg}) : trial[DW-1:0];
            sh_next  = {sh_reg[QW-2:0], ge};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        div_reg <= div_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = sh_reg;

endmodule

// ===== rtl/bis_lane.sv =====
// One color channel: horizontal blend, vertical blend, round.
module bis_lane #(
    parameter int FRAC_BITS = bis_pkg::DEF_FRAC_BITS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    input  bis_pkg::quad_t             quad,
    input  logic [FRAC_BITS-1:0]       fx,
    input  logic [FRAC_BITS-1:0]       fy,
    output logic                       out_valid,
    output logic [bis_pkg::CHAN_W-1:0] chan
);

    localparam int TW = bis_pkg::CHAN_W + FRAC_BITS;
    localparam int VW = bis_pkg::CHAN_W + 2 * FRAC_BITS;
    localparam logic [FRAC_BITS:0] ONE  = (FRAC_BITS+1)'(1) << FRAC_BITS;
    localparam logic [VW-1:0]      HALF = VW'(1) << (2 * FRAC_BITS - 1);

    logic [FRAC_BITS:0]         wx, wy;
    logic [TW-1:0]              top_next, bot_next, top_reg, bot_reg;
    logic [FRAC_BITS-1:0]       fy_reg;
    logic [VW-1:0]              v_next, v_reg, rnd;
    logic [bis_pkg::CHAN_W-1:0] chan_reg;
    logic                       v1_reg, v2_reg, v3_reg;

    always_comb begin
        wx       = ONE - {1'b0, fx};
        top_next = TW'(TW'(quad.a) * TW'(wx)) + TW'(TW'(quad.b) * TW'(fx));
        bot_next = TW'(TW'(quad.d) * TW'(wx)) + TW'(TW'(quad.e) * TW'(fx));
        wy       = ONE - {1'b0, fy_reg};
        v_next   = VW'(VW'(top_reg) * VW'(wy)) + VW'(VW'(bot_reg) * VW'(fy_reg));
        // weights sum to one, so the rounded value never exceeds 255
        rnd      = v_reg + HALF;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            top_reg <= top_next;
            bot_reg <= bot_next;
            fy_reg  <= fy;
        end
        if (v1_reg) begin
            v_reg <= v_next;
        end
        if (v2_reg) begin
            chan_reg <= rnd[VW-1:2*FRAC_BITS];
        end
    end

    assign out_valid = v3_reg;
    assign chan      = chan_reg;

endmodule

// ===== rtl/bis_merge.sv =====
// Output register: joins the lane results into one word.
module bis_merge (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load,
    input  bis_pkg::result_t              result,
    output logic                          free,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bis_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [0:0]                    m_tuser
);

    logic                          valid_reg;
    logic [bis_pkg::M_TDATA_W-1:0] data_reg;
    logic [0:0]                    user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result.err ? '0 : {result.blue, result.green, result.red};
            user_reg <= result.err;
        end
    end

    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

endmodule
